FILE: hw/rtl/aarm_pkg.sv
// Shared types and constants for the axis-angle rotation matrix unit.
// Used by aarm_cordic, aarm_matrix and axis_angle_rotation_matrix_unit.
package aarm_pkg;

    localparam int ANG_W     = 32;
    localparam int CORDIC_W  = 34;
    localparam int NPROD_W   = 32;
    localparam int SPROD_W   = 16 + CORDIC_W;
    localparam int P_W       = NPROD_W + CORDIC_W;
    localparam int ACC_W     = 68;
    localparam int N_ENTRY   = 9;
    localparam int N_PROD    = 6;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = CORDIC_W'(652032874);
    localparam logic signed [CORDIC_W-1:0] Q30_ONE         = CORDIC_W'(1073741824);
    localparam logic signed [ACC_W-1:0]    ACC_HALF        = ACC_W'(536870912);
    localparam logic signed [ACC_W-1:0]    SAT_MAX         = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0]    SAT_MIN         = ACC_W'(-32768);

    localparam logic [31:0] ATAN_TAB [0:31] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
        32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } axis_t;

    // axis component codes
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    // sine term codes; diagonal entries take the cosine term instead
    localparam logic [1:0] SIN_DIAG = 2'd0;
    localparam logic [1:0] SIN_ADD  = 2'd1;
    localparam logic [1:0] SIN_SUB  = 2'd2;

    // axis pair products: xx, xy, xz, yy, yz, zz
    localparam logic [2:0] PROD_IDX [0:N_ENTRY-1] = '{
        3'd0, 3'd1, 3'd2, 3'd1, 3'd3, 3'd4, 3'd2, 3'd4, 3'd5
    };
    localparam logic [1:0] PROD_A [0:N_PROD-1] = '{AX_X, AX_X, AX_X, AX_Y, AX_Y, AX_Z};
    localparam logic [1:0] PROD_B [0:N_PROD-1] = '{AX_X, AX_Y, AX_Z, AX_Y, AX_Z, AX_Z};

    localparam logic [1:0] SIN_IDX [0:N_ENTRY-1] = '{
        AX_X, AX_Z, AX_Y, AX_Z, AX_X, AX_X, AX_Y, AX_X, AX_X
    };
    localparam logic [1:0] SIN_OP [0:N_ENTRY-1] = '{
        SIN_DIAG, SIN_SUB, SIN_ADD, SIN_ADD, SIN_DIAG, SIN_SUB, SIN_SUB, SIN_ADD, SIN_DIAG
    };

    function automatic logic signed [15:0] axis_sel(axis_t a, logic [1:0] sel);
        logic signed [15:0] r;
        unique case (sel)
            AX_X:    r = a.x;
            AX_Y:    r = a.y;
            default: r = a.z;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/aarm_cordic.sv
// Pipelined CORDIC rotator: sine and cosine of the negated binary angle in Q30.
// Carries the axis alongside each request. Depends on aarm_pkg.
module aarm_cordic import aarm_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       ce,
    input  logic                       in_valid,
    input  logic [15:0]                in_angle,
    input  axis_t                      in_axis,
    output logic                       out_valid,
    output logic signed [CORDIC_W-1:0] out_sin,
    output logic signed [CORDIC_W-1:0] out_cos,
    output axis_t                      out_axis
);

    logic                       valid_reg [0:CORDIC_STAGES];
    logic                       flip_reg  [0:CORDIC_STAGES];
    axis_t                      axis_reg  [0:CORDIC_STAGES];
    logic signed [CORDIC_W-1:0] x_reg     [0:CORDIC_STAGES];
    logic signed [CORDIC_W-1:0] y_reg     [0:CORDIC_STAGES];
    logic signed [CORDIC_W-1:0] z_reg     [0:CORDIC_STAGES];

    logic [ANG_W-1:0]           a_neg;
    logic [ANG_W-1:0]           a_rot;
    logic [ANG_W-1:0]           a_fold;
    logic                       flip_next;

    logic                       out_valid_reg;
    logic signed [CORDIC_W-1:0] sin_reg;
    logic signed [CORDIC_W-1:0] cos_reg;
    axis_t                      out_axis_reg;

    always_comb begin
        a_neg     = ANG_W'(0) - {in_angle, 16'd0};
        a_rot     = a_neg + 32'h4000_0000;
        flip_next = a_rot[ANG_W-1];
        a_fold    = flip_next ? {~a_neg[ANG_W-1], a_neg[ANG_W-2:0]} : a_neg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (ce) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            flip_reg[0] <= flip_next;
            axis_reg[0] <= in_axis;
            x_reg[0]    <= CORDIC_GAIN_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= {{(CORDIC_W-ANG_W){a_fold[ANG_W-1]}}, a_fold};
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        logic signed [CORDIC_W-1:0] dx;
        logic signed [CORDIC_W-1:0] dy;
        logic signed [CORDIC_W-1:0] da;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign da = {{(CORDIC_W-32){1'b0}}, ATAN_TAB[i]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i+1] <= 1'b0;
            end else if (ce) begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                flip_reg[i+1] <= flip_reg[i];
                axis_reg[i+1] <= axis_reg[i];
                if (!z_reg[i][CORDIC_W-1]) begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - da;
                end else begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + da;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            out_valid_reg <= valid_reg[CORDIC_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_axis_reg <= axis_reg[CORDIC_STAGES];
            sin_reg <= flip_reg[CORDIC_STAGES] ? -y_reg[CORDIC_STAGES] : y_reg[CORDIC_STAGES];
            cos_reg <= flip_reg[CORDIC_STAGES] ? -x_reg[CORDIC_STAGES] : x_reg[CORDIC_STAGES];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_sin   = sin_reg;
    assign out_cos   = cos_reg;
    assign out_axis  = out_axis_reg;

endmodule

FILE: hw/rtl/aarm_matrix.sv
// Rodrigues matrix pipeline: products, accumulation, rounding and saturation.
// Four register stages, the last one is the output register. Depends on aarm_pkg.
module aarm_matrix import aarm_pkg::*; #(
    parameter int FRAC_BITS = 14
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         ce,
    input  logic                         in_valid,
    input  logic signed [CORDIC_W-1:0]   in_sin,
    input  logic signed [CORDIC_W-1:0]   in_cos,
    input  axis_t                        in_axis,
    output logic                         out_valid,
    output logic [N_ENTRY-1:0][15:0]     out_entry
);

    logic                       v1_reg;
    logic                       v2_reg;
    logic                       v3_reg;
    logic                       v4_reg;

    logic signed [NPROD_W-1:0]  nn_reg  [0:N_PROD-1];
    logic signed [SPROD_W-1:0]  ns1_reg [0:2];
    logic signed [CORDIC_W-1:0] omc_reg;
    logic signed [ACC_W-1:0]    cf1_reg;

    logic signed [P_W-1:0]      p_reg   [0:N_PROD-1];
    logic signed [SPROD_W-1:0]  ns2_reg [0:2];
    logic signed [ACC_W-1:0]    cf2_reg;

    logic signed [ACC_W-1:0]    acc_next [0:N_ENTRY-1];
    logic signed [ACC_W-1:0]    acc_reg  [0:N_ENTRY-1];
    logic [N_ENTRY-1:0][15:0]   res_next;
    logic [N_ENTRY-1:0][15:0]   res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // axis products, sine products, 1 - cos, scaled cos
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < N_PROD; k++) begin
                nn_reg[k] <= axis_sel(in_axis, PROD_A[k]) * axis_sel(in_axis, PROD_B[k]);
            end
            for (int k = 0; k < 3; k++) begin
                ns1_reg[k] <= axis_sel(in_axis, 2'(k)) * in_sin;
            end
            omc_reg <= Q30_ONE - in_cos;
            cf1_reg <= {{(ACC_W-CORDIC_W){in_cos[CORDIC_W-1]}}, in_cos} <<< FRAC_BITS;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < N_PROD; k++) begin
                p_reg[k] <= nn_reg[k] * omc_reg;
            end
            ns2_reg <= ns1_reg;
            cf2_reg <= cf1_reg;
        end
    end

    always_comb begin
        for (int k = 0; k < N_ENTRY; k++) begin
            acc_next[k] = p_reg[PROD_IDX[k]] >>> FRAC_BITS;
            case (SIN_OP[k])
                SIN_ADD: acc_next[k] = acc_next[k] + ns2_reg[SIN_IDX[k]];
                SIN_SUB: acc_next[k] = acc_next[k] - ns2_reg[SIN_IDX[k]];
                default: acc_next[k] = acc_next[k] + cf2_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            acc_reg <= acc_next;
        end
    end

    // round half up, then clamp to 16 bits
    always_comb begin
        logic signed [ACC_W-1:0] rnd;
        for (int k = 0; k < N_ENTRY; k++) begin
            rnd = (acc_reg[k] + ACC_HALF) >>> 30;
            if (rnd > SAT_MAX) begin
                res_next[k] = 16'h7fff;
            end else if (rnd < SAT_MIN) begin
                res_next[k] = 16'h8000;
            end else begin
                res_next[k] = rnd[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_entry = res_reg;

endmodule

FILE: hw/rtl/axis_angle_rotation_matrix_unit.sv
// Axis-angle rotation matrix unit: binary angle and unit axis in, nine Q1.14 entries out.
// Top level; instantiates aarm_cordic and aarm_matrix, depends on aarm_pkg.
//
// Takes one request per clock and returns one result per request, in order. The pipeline is
// one angle fold stage, one CORDIC stage per iteration, one sign
// stage, then four matrix stages (axis products, product with 1 - cos, accumulate, round
// and saturate). The whole pipeline advances whenever the output register is empty or
// being taken, so with m_ready held high a new request enters every cycle; while the
// output is stalled, s_ready is low and every stage holds.
module axis_angle_rotation_matrix_unit import aarm_pkg::*; #(
    parameter int FRAC_BITS     = 14,
    parameter int CORDIC_STAGES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_angle,
    input  logic [15:0] s_axis_x,
    input  logic [15:0] s_axis_y,
    input  logic [15:0] s_axis_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_r0c0,
    output logic [15:0] m_r0c1,
    output logic [15:0] m_r0c2,
    output logic [15:0] m_r1c0,
    output logic [15:0] m_r1c1,
    output logic [15:0] m_r1c2,
    output logic [15:0] m_r2c0,
    output logic [15:0] m_r2c1,
    output logic [15:0] m_r2c2
);

    logic                       ce;
    axis_t                      axis_in;
    logic                       cs_valid;
    logic signed [CORDIC_W-1:0] cs_sin;
    logic signed [CORDIC_W-1:0] cs_cos;
    axis_t                      cs_axis;
    logic [N_ENTRY-1:0][15:0]   entry;

    assign ce      = !m_valid || m_ready;
    assign s_ready = ce;

    assign axis_in.x = s_axis_x;
    assign axis_in.y = s_axis_y;
    assign axis_in.z = s_axis_z;

    aarm_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_valid),
        .in_angle  (s_angle),
        .in_axis   (axis_in),
        .out_valid (cs_valid),
        .out_sin   (cs_sin),
        .out_cos   (cs_cos),
        .out_axis  (cs_axis)
    );

    aarm_matrix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (cs_valid),
        .in_sin    (cs_sin),
        .in_cos    (cs_cos),
        .in_axis   (cs_axis),
        .out_valid (m_valid),
        .out_entry (entry)
    );

    assign m_r0c0 = entry[0];
    assign m_r0c1 = entry[1];
    assign m_r0c2 = entry[2];
    assign m_r1c0 = entry[3];
    assign m_r1c1 = entry[4];
    assign m_r1c2 = entry[5];
    assign m_r2c0 = entry[6];
    assign m_r2c1 = entry[7];
    assign m_r2c2 = entry[8];

endmodule
